// ----- rtl/tcss_pkg.sv -----
// shared types and codes of the threshold crossing stage switcher
`default_nettype none
package tcss_pkg;

    // input opcodes
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_MOVE   = 2'd2;

    // one stage row as held in a cell
    typedef struct packed {
        logic               valid;
        logic [3:0]         ctl;
        logic signed [15:0] thr;
        logic [15:0]        sw;
        logic               eng_up;
        logic               eng_down;
        logic               rel_up;
        logic               rel_down;
    } row_t;

    // command broadcast to every cell of the chain
    typedef enum logic [2:0] {
        CMD_HOLD   = 3'd0,
        CMD_CLEAR  = 3'd1,
        CMD_INSERT = 3'd2,
        CMD_ROT_UP = 3'd3,
        CMD_ROT_DN = 3'd4
    } cmd_t;

endpackage
`default_nettype wire

// ----- rtl/tcss_cell.sv -----
// one cell of the sorted row chain: holds a row, inserts in order, rotates
`default_nettype none
module tcss_cell #(
    parameter bit FIRST = 1'b0
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire tcss_pkg::cmd_t cmd,
    input  wire tcss_pkg::row_t new_row,
    input  wire tcss_pkg::row_t left_row,
    input  wire tcss_pkg::row_t right_row,
    output tcss_pkg::row_t      row
);
    import tcss_pkg::*;

    row_t row_reg;
    row_t row_next;
    logic left_ok;
    logic left_gt;
    logic self_gt;

    // ordering against the incoming row
    assign left_ok = FIRST || left_row.valid;
    assign left_gt = !FIRST && left_row.valid && (left_row.thr > new_row.thr);
    assign self_gt = row_reg.valid && (row_reg.thr > new_row.thr);

    // next row of the cell
    always_comb begin
        row_next = row_reg;
        case (cmd)
            CMD_HOLD: begin
                row_next = row_reg;
            end
            CMD_CLEAR: begin
                row_next.valid = 1'b0;
            end
            CMD_INSERT: begin
                if (left_gt) begin
                    row_next = left_row;
                end else if (left_ok && (!row_reg.valid || self_gt)) begin
                    row_next = new_row;
                    row_next.valid = 1'b1;
                end
            end
            CMD_ROT_UP: begin
                row_next = right_row;
            end
            CMD_ROT_DN: begin
                row_next = left_row;
            end
            default: begin
                row_next = row_reg;
            end
        endcase
    end

    // row register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg.valid <= 1'b0;
        end else begin
            row_reg <= row_next;
        end
    end

    assign row = row_reg;

endmodule
`default_nettype wire

// ----- rtl/threshold_crossing_stage_switcher_unit.sv -----
// top level: row chain, walk sequencer, engaged records and result stage
// Usage: one input stream (s_*) carries commands, one result stream (m_*)
// carries switch changes. s_tuser holds the opcode (clear, insert, move).
// Clear and insert are each taken in the idle state; an insert puts the row
// into the chain of cells in threshold order, and is dropped when the chain
// is full or the control number is out of range.
// A move rotates the whole chain once through its head cell (the first cell
// on a rising move, the last on a falling one), one row a cycle, but a row
// that gives two changes holds the walk for the first, and the walk pauses
// while no room is left for a new beat, as when the receiver stalls.
// Each change is one m_* beat; m_tlast marks the final change of a move.
// One change is held back so that the final one can be flagged; a move that
// crosses nothing gives no beat. A new command is taken only when the walk
// has ended; the last beat may still wait in the output register.
// Reset empties the chain and clears all engaged records; a stalled result
// beat holds its value until taken.
`default_nettype none
module threshold_crossing_stage_switcher_unit #(
    parameter int ROW_CAPACITY  = 32,
    parameter int CONTROL_COUNT = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // control_number, row_threshold, row_switch, engage_up, engage_down,
    // release_up, release_down, start_value, end_value
    input  wire logic [71:0] s_tdata,
    // opcode
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // switch_number
    output logic [15:0]      m_tdata,
    // switch_on
    output logic             m_tuser,
    output logic             m_tlast
);
    import tcss_pkg::*;

    localparam int STEP_W  = (ROW_CAPACITY > 1) ? $clog2(ROW_CAPACITY) : 1;
    localparam int COUNT_W = $clog2(ROW_CAPACITY + 1);
    localparam int CTL_W   = (CONTROL_COUNT > 1) ? $clog2(CONTROL_COUNT) : 1;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_WALK  = 3'b010,
        ST_FLUSH = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // input fields
    logic [3:0]         in_ctl;
    logic signed [15:0] in_from, in_to;
    logic               s_fire;
    logic               ctl_ok;
    row_t               new_row;

    assign in_ctl   = s_tdata[3:0];
    assign in_from  = s_tdata[55:40];
    assign in_to    = s_tdata[71:56];
    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign ctl_ok   = {5'd0, in_ctl} < 9'(CONTROL_COUNT);

    always_comb begin
        new_row.valid    = 1'b1;
        new_row.ctl      = in_ctl;
        new_row.thr      = s_tdata[19:4];
        new_row.sw       = s_tdata[35:20];
        new_row.eng_up   = s_tdata[36];
        new_row.eng_down = s_tdata[37];
        new_row.rel_up   = s_tdata[38];
        new_row.rel_down = s_tdata[39];
    end

    // chain of cells
    cmd_t cmd;
    row_t cell_row [ROW_CAPACITY];

    for (genvar i = 0; i < ROW_CAPACITY; i++) begin : g_cell
        tcss_cell #(
            .FIRST(i == 0)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cmd       (cmd),
            .new_row   (new_row),
            .left_row  (cell_row[(i + ROW_CAPACITY - 1) % ROW_CAPACITY]),
            .right_row (cell_row[(i + 1) % ROW_CAPACITY]),
            .row       (cell_row[i])
        );
    end

    // walk and engaged state
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [3:0]         ctl_reg, ctl_next;
    logic signed [15:0] from_reg, from_next, to_reg, to_next;
    logic               rising_reg, rising_next;
    logic               off_done_reg, off_done_next;
    logic               work_v_reg, work_v_next;
    logic [15:0]        work_sw_reg, work_sw_next;
    logic               eng_valid_reg [CONTROL_COUNT];
    logic [15:0]        eng_sw_reg [CONTROL_COUNT];
    logic [CTL_W-1:0]   ctl_idx, walk_idx;

    assign ctl_idx  = CTL_W'(in_ctl);
    assign walk_idx = CTL_W'(ctl_reg);

    // result staging: held beat and output register
    logic        held_v_reg, held_v_next;
    logic [15:0] held_sw_reg, held_sw_next;
    logic        held_on_reg, held_on_next;
    logic        out_v_reg, out_v_next;
    logic [15:0] out_sw_reg, out_sw_next;
    logic        out_on_reg, out_on_next;
    logic        out_last_reg, out_last_next;
    logic        can_push, gen_ok;

    assign can_push = !out_v_reg || m_tready;
    assign gen_ok   = !held_v_reg || can_push;

    // head row decode
    row_t head;
    logic crossed, hit, eng, rel, need_off;

    assign head    = rising_reg ? cell_row[0] : cell_row[ROW_CAPACITY-1];
    assign crossed = rising_reg ? (from_reg < head.thr && head.thr <= to_reg)
                                : (to_reg <= head.thr && head.thr < from_reg);
    assign hit      = head.valid && (head.ctl == ctl_reg) && crossed;
    assign eng      = rising_reg ? head.eng_up : head.eng_down;
    assign rel      = rising_reg ? head.rel_up : head.rel_down;
    assign need_off = work_v_reg && (work_sw_reg != head.sw) && !off_done_reg;

    // sequencer
    always_comb begin
        logic        advance;
        logic        gen;
        logic [15:0] gen_sw;
        logic        gen_on;
        state_next    = state_reg;
        cmd           = CMD_HOLD;
        count_next    = count_reg;
        step_next     = step_reg;
        ctl_next      = ctl_reg;
        from_next     = from_reg;
        to_next       = to_reg;
        rising_next   = rising_reg;
        off_done_next = off_done_reg;
        work_v_next   = work_v_reg;
        work_sw_next  = work_sw_reg;
        held_v_next   = held_v_reg;
        held_sw_next  = held_sw_reg;
        held_on_next  = held_on_reg;
        out_v_next    = out_v_reg && !m_tready;
        out_sw_next   = out_sw_reg;
        out_on_next   = out_on_reg;
        out_last_next = out_last_reg;
        advance       = 1'b0;
        gen           = 1'b0;
        gen_sw        = head.sw;
        gen_on        = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    case (s_tuser)
                        OP_CLEAR: begin
                            cmd        = CMD_CLEAR;
                            count_next = '0;
                        end
                        OP_INSERT: begin
                            if (ctl_ok && count_reg < COUNT_W'(ROW_CAPACITY)) begin
                                cmd        = CMD_INSERT;
                                count_next = count_reg + COUNT_W'(1);
                            end
                        end
                        OP_MOVE: begin
                            if (ctl_ok && in_from != in_to) begin
                                state_next    = ST_WALK;
                                step_next     = '0;
                                ctl_next      = in_ctl;
                                from_next     = in_from;
                                to_next       = in_to;
                                rising_next   = in_to > in_from;
                                off_done_next = 1'b0;
                                work_v_next   = eng_valid_reg[ctl_idx];
                                work_sw_next  = eng_sw_reg[ctl_idx];
                            end
                        end
                        default: begin
                            cmd = CMD_HOLD;
                        end
                    endcase
                end
            end
            ST_WALK: begin
                if (!hit || (!eng && !rel)) begin
                    advance = 1'b1;
                end else if (gen_ok) begin
                    gen = 1'b1;
                    if (eng) begin
                        if (need_off) begin
                            gen_sw        = work_sw_reg;
                            gen_on        = 1'b0;
                            off_done_next = 1'b1;
                        end else begin
                            gen_on       = 1'b1;
                            work_v_next  = 1'b1;
                            work_sw_next = head.sw;
                            advance      = 1'b1;
                        end
                    end else begin
                        gen_on = 1'b0;
                        if (work_v_reg && work_sw_reg == head.sw) begin
                            work_v_next = 1'b0;
                        end
                        advance = 1'b1;
                    end
                end
                if (advance) begin
                    cmd           = rising_reg ? CMD_ROT_UP : CMD_ROT_DN;
                    off_done_next = 1'b0;
                    step_next     = step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(ROW_CAPACITY - 1)) begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (!held_v_reg) begin
                    state_next = ST_IDLE;
                end else if (can_push) begin
                    out_v_next    = 1'b1;
                    out_sw_next   = held_sw_reg;
                    out_on_next   = held_on_reg;
                    out_last_next = 1'b1;
                    held_v_next   = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        // a new beat pushes the held one out
        if (gen) begin
            if (held_v_reg) begin
                out_v_next    = 1'b1;
                out_sw_next   = held_sw_reg;
                out_on_next   = held_on_reg;
                out_last_next = 1'b0;
            end
            held_v_next  = 1'b1;
            held_sw_next = gen_sw;
            held_on_next = gen_on;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            held_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            held_v_reg <= held_v_next;
            out_v_reg  <= out_v_next;
        end
    end

    // walk and payload registers
    always_ff @(posedge aclk) begin
        step_reg     <= step_next;
        ctl_reg      <= ctl_next;
        from_reg     <= from_next;
        to_reg       <= to_next;
        rising_reg   <= rising_next;
        off_done_reg <= off_done_next;
        work_v_reg   <= work_v_next;
        work_sw_reg  <= work_sw_next;
        held_sw_reg  <= held_sw_next;
        held_on_reg  <= held_on_next;
        out_sw_reg   <= out_sw_next;
        out_on_reg   <= out_on_next;
        out_last_reg <= out_last_next;
    end

    // engaged records, written back when the walk ends
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CONTROL_COUNT; i++) begin
                eng_valid_reg[i] <= 1'b0;
            end
        end else if (s_fire && s_tuser == OP_CLEAR) begin
            for (int i = 0; i < CONTROL_COUNT; i++) begin
                eng_valid_reg[i] <= 1'b0;
            end
        end else if (state_reg == ST_FLUSH && state_next == ST_IDLE) begin
            eng_valid_reg[walk_idx] <= work_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_FLUSH && state_next == ST_IDLE) begin
            eng_sw_reg[walk_idx] <= work_sw_reg;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_sw_reg;
    assign m_tuser  = out_on_reg;
    assign m_tlast  = out_last_reg;

endmodule
`default_nettype wire

// ----- bench/tcss_checker.sv -----
// stream monitor, change predictor and scoreboard for the stage switcher
`default_nettype none
module tcss_checker #(
    parameter int ROW_CAPACITY  = 32,
    parameter int CONTROL_COUNT = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [71:0] s_tdata,
    input  wire logic [1:0]  s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [15:0] m_tdata,
    input  wire logic        m_tuser,
    input  wire logic        m_tlast,
    output int               fail_count,
    output int               changes_pending,
    output int               changes_seen,
    output int               commands_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import tcss_pkg::*;

    typedef struct {
        logic [3:0]         ctl;
        logic signed [15:0] thr;
        logic [15:0]        sw;
        bit                 eng_up;
        bit                 eng_down;
        bit                 rel_up;
        bit                 rel_down;
    } stage_entry_t;

    typedef struct {
        logic [15:0] sw;
        logic        on;
        logic        last;
    } switch_change_t;

    stage_entry_t   stage_rows [ROW_CAPACITY];
    int             rows_held;
    bit             held_valid [CONTROL_COUNT];
    logic [15:0]    held_switch [CONTROL_COUNT];
    switch_change_t change_q [$];

    task automatic clear_stages();
        rows_held = 0;
        for (int i = 0; i < CONTROL_COUNT; i++) held_valid[i] = 0;
    endtask

    // one mismatch line
    task automatic report_mismatch(string what, int got, int want);
        $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    // work out the switch changes that one accepted command causes
    task automatic predict_changes(logic [1:0] op, logic [71:0] d);
        logic [3:0]         c;
        logic signed [15:0] from_v;
        logic signed [15:0] to_v;
        stage_entry_t       e;
        switch_change_t     found [$];
        switch_change_t     one;
        bit                 rising;
        bit                 crossed;
        bit                 eng;
        bit                 rel;
        int                 pos;
        int                 k;
        c      = d[3:0];
        from_v = d[55:40];
        to_v   = d[71:56];
        case (op)
            OP_CLEAR: begin
                clear_stages();
            end
            OP_INSERT: begin
                if (c < CONTROL_COUNT && rows_held < ROW_CAPACITY) begin
                    e.ctl = c;
                    e.thr = d[19:4];
                    e.sw = d[35:20];
                    e.eng_up = d[36];
                    e.eng_down = d[37];
                    e.rel_up = d[38];
                    e.rel_down = d[39];
                    // stable order: after every row with an equal or lower threshold
                    pos = rows_held;
                    while (pos > 0 && stage_rows[pos-1].thr > e.thr) pos--;
                    for (k = rows_held; k > pos; k--) stage_rows[k] = stage_rows[k-1];
                    stage_rows[pos] = e;
                    rows_held++;
                end
            end
            OP_MOVE: begin
                if (c < CONTROL_COUNT && from_v != to_v) begin
                    rising = to_v > from_v;
                    for (int i = 0; i < rows_held; i++) begin
                        k = rising ? i : rows_held - 1 - i;
                        e = stage_rows[k];
                        if (e.ctl == c) begin
                            crossed = rising ? (from_v < e.thr && e.thr <= to_v)
                                             : (to_v <= e.thr && e.thr < from_v);
                            eng = rising ? e.eng_up : e.eng_down;
                            rel = rising ? e.rel_up : e.rel_down;
                            if (crossed && eng) begin
                                // release the previously engaged switch first
                                if (held_valid[c] && held_switch[c] != e.sw) begin
                                    one = '{sw: held_switch[c], on: 1'b0, last: 1'b0};
                                    found = {found, one};
                                end
                                held_valid[c] = 1;
                                held_switch[c] = e.sw;
                                one = '{sw: e.sw, on: 1'b1, last: 1'b0};
                                found = {found, one};
                            end else if (crossed && rel) begin
                                if (held_valid[c] && held_switch[c] == e.sw) held_valid[c] = 0;
                                one = '{sw: e.sw, on: 1'b0, last: 1'b0};
                                found = {found, one};
                            end
                        end
                    end
                    if (found.size() > 0) found[found.size()-1].last = 1'b1;
                    change_q = {change_q, found};
                end
            end
            default: begin
            end
        endcase
    endtask

    // input beats first, then result beats of the same edge
    always @(posedge aclk) begin
        switch_change_t want;
        if (!aresetn) begin
            clear_stages();
            change_q.delete();
            fail_count = 0;
            changes_seen = 0;
            commands_seen = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                commands_seen++;
                predict_changes(s_tuser, s_tdata);
            end
            if (m_tvalid && m_tready) begin
                changes_seen++;
                if (change_q.size() == 0) begin
                    report_mismatch("unexpected result beat", m_tdata, 0);
                end else begin
                    want = change_q.pop_front();
                    if (m_tdata !== want.sw) report_mismatch("switch_number", m_tdata, want.sw);
                    if (m_tuser !== want.on) report_mismatch("switch_on", m_tuser, want.on);
                    if (m_tlast !== want.last) report_mismatch("last_change", m_tlast, want.last);
                end
            end
        end
        changes_pending = change_q.size();
    end
endmodule
`default_nettype wire

// ----- bench/tb_threshold_crossing_stage_switcher_unit.sv -----
// testbench top: stimulus, handshake idling, long receiver stall and verdict
`default_nettype none
module tb_threshold_crossing_stage_switcher_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import tcss_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_PER_PHASE = 91;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    int fail_count;
    int changes_pending;
    int changes_seen;
    int commands_seen;

    int tx_idle_pct = 19;
    int rx_idle_pct = 73;
    bit long_stall_req = 0;
    int stall_left = 0;

    always #1 aclk = ~aclk;

    threshold_crossing_stage_switcher_unit i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    tcss_checker i_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .fail_count(fail_count), .changes_pending(changes_pending),
        .changes_seen(changes_seen), .commands_seen(commands_seen)
    );

    // receiver: random back-pressure, or a long hold-off when requested
    always @(posedge aclk) begin
        if (long_stall_req) begin
            long_stall_req = 0;
            stall_left = 400;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic logic [71:0] pack_command(logic [3:0] ctl, logic [15:0] thr,
                                                 logic [15:0] sw, logic [3:0] flags,
                                                 logic [15:0] from_v, logic [15:0] to_v);
        return {to_v, from_v, flags, sw, thr, ctl};
    endfunction

    // offer one beat, with a random gap before it
    task automatic send_beat(logic [1:0] op, logic [71:0] d);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= d;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_insert(logic [3:0] ctl, logic [15:0] thr, logic [15:0] sw,
                               logic [3:0] flags);
        send_beat(OP_INSERT, pack_command(ctl, thr, sw, flags, 16'($urandom), 16'($urandom)));
    endtask

    task automatic send_move(logic [3:0] ctl, logic [15:0] from_v, logic [15:0] to_v);
        send_beat(OP_MOVE, pack_command(ctl, 16'($urandom), 16'($urandom), 4'($urandom),
                                        from_v, to_v));
    endtask

    function automatic logic [3:0] pick_control();
        return ($urandom_range(9) < 8) ? 4'($urandom_range(3)) : 4'($urandom);
    endfunction

    function automatic logic [15:0] pick_value();
        return ($urandom_range(9) < 8) ? 16'($urandom_range(40) - 20) : 16'($urandom);
    endfunction

    // mostly inserts and moves on a few controls with nearby values
    task automatic send_random_command();
        int r;
        r = $urandom_range(99);
        if (r < 4) begin
            send_beat(OP_CLEAR, 72'({$urandom, $urandom, $urandom}));
        end else if (r < 6) begin
            send_beat(OP_UNUSED, 72'({$urandom, $urandom, $urandom}));
        end else if (r < 45) begin
            send_insert(pick_control(), pick_value(),
                        ($urandom_range(3) != 0) ? 16'($urandom_range(1, 4)) : 16'($urandom),
                        4'($urandom));
        end else begin
            send_move(pick_control(), pick_value(), pick_value());
        end
    endtask

    // clear, then more inserts than the table holds, then moves over it
    task automatic send_full_table();
        send_beat(OP_CLEAR, '0);
        for (int i = 0; i < 34; i++) begin
            send_insert(4'($urandom_range(1)), pick_value(), 16'($urandom_range(1, 6)),
                        4'($urandom));
        end
        for (int i = 0; i < 4; i++) send_move(4'($urandom_range(1)), pick_value(), pick_value());
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part: extremes, equal thresholds, every opcode
        send_beat(OP_CLEAR, '0);
        send_beat(OP_UNUSED, '1);
        send_insert(4'd1, 16'h8000, 16'h0000, 4'b0001);
        send_insert(4'd1, 16'h7fff, 16'hffff, 4'b1111);
        send_insert(4'd1, 16'h0000, 16'h0005, 4'b0011);
        send_insert(4'd1, 16'h0000, 16'h0006, 4'b1100);
        send_insert(4'd1, 16'h000a, 16'h0005, 4'b1000);
        send_insert(4'd15, 16'h0000, 16'haaaa, 4'b1111);
        send_move(4'd1, 16'h8000, 16'h7fff);
        send_move(4'd1, 16'h7fff, 16'h8000);
        send_move(4'd1, 16'hffff, 16'h0000);
        send_move(4'd1, 16'h0000, 16'hffff);
        send_move(4'd1, 16'h0000, 16'h0000);
        send_move(4'd2, 16'h8000, 16'h7fff);
        send_move(4'd15, 16'h8000, 16'h7fff);
        send_move(4'd15, 16'h7fff, 16'h8000);
        send_beat(OP_CLEAR, '1);
        send_move(4'd1, 16'h8000, 16'h7fff);

        // sender idles a little, receiver a lot
        for (int i = 0; i < RANDOM_PER_PHASE; i++) send_random_command();

        // sender idles a lot, receiver a little
        tx_idle_pct = 73;
        rx_idle_pct = 19;
        send_full_table();
        for (int i = 0; i < RANDOM_PER_PHASE; i++) send_random_command();

        // no idling, with one long receiver hold-off over a full table
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        long_stall_req = 1;
        send_full_table();
        for (int i = 0; i < RANDOM_PER_PHASE; i++) send_random_command();
        s_tvalid <= 1'b0;

        wait (changes_pending == 0);
        repeat (80) @(posedge aclk);

        $display("covered %0d commands and %0d switch changes over three idling phases",
                 commands_seen, changes_seen);
        $display("including full-table inserts and a long result stall");
        if (fail_count == 0 && changes_pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // run limit
    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire
